[design/pjsc_pkg.sv]
// ----------------------------------------------------------------------------
// pjsc_pkg: shared types and constants for the PI joint servo controller
// Fixed-point constants, register indexes and the multiplier request type.
// ----------------------------------------------------------------------------
package pjsc_pkg;

  localparam int JOINT_COUNT = 2;
  localparam int JIDX_W      = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  // configuration register indexes
  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [1:0] REG_STEP_TIME  = 2'd2;

  localparam logic [15:0] PROP_GAIN_RST  = 16'd4096;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd2048;
  localparam logic [15:0] STEP_TIME_RST  = 16'd1311;

  // multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 28;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // degrees to Q13 radians: deg * 157 * 8192 / 9000 = deg * 160768 / 1125
  localparam longint DEG_MUL_L     = 160768;
  localparam longint DEG_DIV_L     = 1125;
  localparam int     DEG_SHIFT     = 37;
  localparam longint RECIP_DEG_L   = (64'sd1 <<< DEG_SHIFT) / DEG_DIV_L;

  // pulse: cmd * 1000 / PI_Q13
  localparam longint PI_Q13_L      = 25723;
  localparam longint PULSE_SPAN_L  = 1000;
  localparam int     PULSE_SHIFT   = 40;
  localparam longint RECIP_PULSE_L = (64'sd1 <<< PULSE_SHIFT) / PI_Q13_L;

  localparam logic [MUL_B_W-1:0] DEG_MUL     = MUL_B_W'(DEG_MUL_L);
  localparam logic [MUL_B_W-1:0] DEG_DIV     = MUL_B_W'(DEG_DIV_L);
  localparam logic [MUL_B_W-1:0] RECIP_DEG   = MUL_B_W'(RECIP_DEG_L);
  localparam logic [MUL_B_W-1:0] PI_Q13      = MUL_B_W'(PI_Q13_L);
  localparam logic [MUL_B_W-1:0] PULSE_SPAN  = MUL_B_W'(PULSE_SPAN_L);
  localparam logic [MUL_B_W-1:0] RECIP_PULSE = MUL_B_W'(RECIP_PULSE_L);
  localparam logic [10:0]        PULSE_BASE  = 11'd1000;
  localparam logic [10:0]        PULSE_MAX   = 11'd2000;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

[design/pjsc_mul.sv]
// ----------------------------------------------------------------------------
// pjsc_mul: shared signed multiplier
// One registered signed multiply per enabled cycle, reused by the sequencer.
// ----------------------------------------------------------------------------
module pjsc_mul (
  input  logic                                   clk_i,
  input  pjsc_pkg::mul_req_t                     req_i,
  output logic signed [pjsc_pkg::MUL_P_W-1:0]    prod_o
);
  import pjsc_pkg::*;

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

[design/pi_joint_servo_controller.sv]
// ----------------------------------------------------------------------------
// pi_joint_servo_controller: PI position loop for servo joints
// Per-joint saturating integral, PI command, clamp and servo pulse mapping.
// ----------------------------------------------------------------------------
// A sample runs through the sequencer states from acceptance to the result
// register, waiting in S_OUT while a held result is stalled by out_stall_i.
// All products go through one registered 32x28 signed multiplier, used at most
// once per step of the sequencer; the divisions by 1125 and by pi are
// reciprocal multiplies with a one-step correction. in_stall_o is high while a
// sample is in flight. A finished result sits in the output register, so the
// next sample is taken while it waits. The user must write configuration only
// while idle; the block itself does not enforce this.
module pi_joint_servo_controller (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [15:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     joint_i,
  input  logic signed [15:0]       target_angle_i,
  input  logic [8:0]               measured_deg_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     joint_out_o,
  output logic [10:0]              pulse_us_o
);
  import pjsc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MQ   = 4'd2;
  localparam logic [3:0] S_MC   = 4'd3;
  localparam logic [3:0] S_MEAS = 4'd4;
  localparam logic [3:0] S_ERR  = 4'd5;
  localparam logic [3:0] S_INC  = 4'd6;
  localparam logic [3:0] S_INT  = 4'd7;
  localparam logic [3:0] S_ACC1 = 4'd8;
  localparam logic [3:0] S_ACC2 = 4'd9;
  localparam logic [3:0] S_CMD  = 4'd10;
  localparam logic [3:0] S_PY   = 4'd11;
  localparam logic [3:0] S_PQ   = 4'd12;
  localparam logic [3:0] S_PC   = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0]  state_q, state_d;

  logic [15:0] prop_gain_q, integ_gain_q, step_time_q;

  // sample registers
  logic               joint_q;
  logic [JIDX_W-1:0]  jidx_q;
  logic signed [15:0] target_q;
  logic [8:0]         deg_q;

  // working registers
  logic [26:0]        x_q,    x_d;
  logic [16:0]        est_q,  est_d;
  logic [16:0]        meas_q, meas_d;
  logic signed [17:0] err_q,  err_d;
  logic signed [31:0] integ_q, integ_d;
  logic signed [49:0] acc_q,  acc_d;
  logic [14:0]        cmd_q,  cmd_d;
  logic [24:0]        y_q,    y_d;
  logic [10:0]        est2_q, est2_d;

  logic signed [31:0] integ_mem_q [JOINT_COUNT];
  logic               integ_we;

  logic               out_valid_q;
  logic               joint_out_q;
  logic [10:0]        pulse_q;
  logic               out_load;

  mul_req_t                  mreq;
  logic signed [MUL_P_W-1:0] prod;

  logic               in_acc;
  logic [27:0]        rem_meas;
  logic [25:0]        rem_pulse;
  logic signed [MUL_P_W-1:0] inc_full;
  logic signed [33:0] integ_sum;
  logic signed [49:0] cmd_sum;
  logic [10:0]        pulse_d;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  pjsc_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PROP_GAIN_RST;
      integ_gain_q <= INTEG_GAIN_RST;
      step_time_q  <= STEP_TIME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:  prop_gain_q  <= cfg_data_i;
        REG_INTEG_GAIN: integ_gain_q <= cfg_data_i;
        REG_STEP_TIME:  step_time_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // datapath helpers
  always_comb begin
    rem_meas  = {1'b0, x_q} - prod[27:0];
    rem_pulse = {1'b0, y_q} - prod[25:0];
    inc_full  = prod >>> 16;
    integ_sum = {{2{integ_mem_q[jidx_q][31]}}, integ_mem_q[jidx_q]} + inc_full[33:0];
    cmd_sum   = (acc_q >>> 12) + $signed({33'b0, meas_q});
    pulse_d   = PULSE_BASE + est2_q + 11'(rem_pulse >= 26'(PI_Q13));
  end

  // sequencer and multiplier operand selection
  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    est_d     = est_q;
    meas_d    = meas_q;
    err_d     = err_q;
    integ_d   = integ_q;
    acc_d     = acc_q;
    cmd_d     = cmd_q;
    y_d       = y_q;
    est2_d    = est2_q;
    integ_we  = 1'b0;
    out_load  = 1'b0;
    mreq.en   = 1'b0;
    mreq.a    = '0;
    mreq.b    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_MX;
      end
      S_MX: begin
        mreq.en = 1'b1;
        mreq.a  = {23'b0, deg_q};
        mreq.b  = DEG_MUL;
        state_d = S_MQ;
      end
      S_MQ: begin
        x_d     = prod[26:0];
        mreq.en = 1'b1;
        mreq.a  = {5'b0, prod[26:0]};
        mreq.b  = RECIP_DEG;
        state_d = S_MC;
      end
      S_MC: begin
        est_d   = prod[DEG_SHIFT+16:DEG_SHIFT];
        mreq.en = 1'b1;
        mreq.a  = {15'b0, prod[DEG_SHIFT+16:DEG_SHIFT]};
        mreq.b  = DEG_DIV;
        state_d = S_MEAS;
      end
      S_MEAS: begin
        // estimate is at most one low
        meas_d  = est_q + 17'(rem_meas >= DEG_DIV);
        state_d = S_ERR;
      end
      S_ERR: begin
        err_d   = {{2{target_q[15]}}, target_q} - $signed({1'b0, meas_q});
        state_d = S_INC;
      end
      S_INC: begin
        mreq.en = 1'b1;
        mreq.a  = {{14{err_q[17]}}, err_q};
        mreq.b  = {12'b0, step_time_q};
        state_d = S_INT;
      end
      S_INT: begin
        integ_we = 1'b1;
        if (integ_sum > 34'sh0_7FFF_FFFF) begin
          integ_d = 32'sh7FFF_FFFF;
        end else if (integ_sum < -34'sh0_8000_0000) begin
          integ_d = -32'sh8000_0000;
        end else begin
          integ_d = integ_sum[31:0];
        end
        mreq.en = 1'b1;
        mreq.a  = {{14{err_q[17]}}, err_q};
        mreq.b  = {12'b0, prop_gain_q};
        state_d = S_ACC1;
      end
      S_ACC1: begin
        acc_d   = prod[49:0];
        mreq.en = 1'b1;
        mreq.a  = integ_q;
        mreq.b  = {12'b0, integ_gain_q};
        state_d = S_ACC2;
      end
      S_ACC2: begin
        acc_d   = acc_q + prod[49:0];
        state_d = S_CMD;
      end
      S_CMD: begin
        if (cmd_sum < 0) begin
          cmd_d = '0;
        end else if (cmd_sum > $signed({22'b0, PI_Q13})) begin
          cmd_d = PI_Q13[14:0];
        end else begin
          cmd_d = cmd_sum[14:0];
        end
        state_d = S_PY;
      end
      S_PY: begin
        mreq.en = 1'b1;
        mreq.a  = {17'b0, cmd_q};
        mreq.b  = PULSE_SPAN;
        state_d = S_PQ;
      end
      S_PQ: begin
        y_d     = prod[24:0];
        mreq.en = 1'b1;
        mreq.a  = {7'b0, prod[24:0]};
        mreq.b  = RECIP_PULSE;
        state_d = S_PC;
      end
      S_PC: begin
        est2_d  = prod[PULSE_SHIFT+10:PULSE_SHIFT];
        mreq.en = 1'b1;
        mreq.a  = {21'b0, prod[PULSE_SHIFT+10:PULSE_SHIFT]};
        mreq.b  = PI_Q13;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      joint_q  <= joint_i;
      jidx_q   <= (JOINT_COUNT == 1) ? '0 : JIDX_W'(joint_i);
      target_q <= target_angle_i;
      deg_q    <= measured_deg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    est_q   <= est_d;
    meas_q  <= meas_d;
    err_q   <= err_d;
    integ_q <= integ_d;
    acc_q   <= acc_d;
    cmd_q   <= cmd_d;
    y_q     <= y_d;
    est2_q  <= est2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < JOINT_COUNT; i++) integ_mem_q[i] <= '0;
    end else if (integ_we) begin
      integ_mem_q[jidx_q] <= integ_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      joint_out_q <= joint_q;
      pulse_q     <= pulse_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign joint_out_o = joint_out_q;
  assign pulse_us_o  = pulse_q;

  a_out_after_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result appeared without finishing the sequence");

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pulse_us_o >= PULSE_BASE) && (pulse_us_o <= PULSE_MAX))
    else $error("pulse width out of range");

  a_integ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_INT) |=> $stable(integ_mem_q[0]))
    else $error("integral changed outside its update step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_MX))
    else $error("accepted transaction did not start the sequence");

endmodule
